// ===== rtl/udiv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the pipelined unsigned divider.
// No dependencies; the interfaces and the top level import this package.
package udiv_pkg;

    // Width of each port field, fixed by the word format.
    localparam int FIELD_WIDTH = 64;

    // Default division width (bits actually used from each field).
    localparam int DEF_DATA_WIDTH = 64;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] dividend;
        logic [FIELD_WIDTH-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] quotient;
        logic [FIELD_WIDTH-1:0] remainder;
        logic                   divide_by_zero;
    } t_div_rsp;

endpackage

// ===== rtl/udiv_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the divider request and response words.
// Depends on udiv_pkg for the payload types.
interface udiv_req_if import udiv_pkg::*; ();
    logic     valid;
    logic     ready;
    t_div_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface udiv_rsp_if import udiv_pkg::*; ();
    logic     valid;
    logic     ready;
    t_div_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/udiv_stage.sv =====
`timescale 1ns / 1ps
// One restoring shift-subtract step with its own pipeline register.
// Stand-alone; instantiated once per quotient bit by the top level.
module udiv_stage #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // upstream side
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_num,
    input  logic [WIDTH-1:0] i_den,
    input  logic [WIDTH-1:0] i_quo,
    input  logic [WIDTH-1:0] i_rem,
    // downstream side
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_num,
    output logic [WIDTH-1:0] o_den,
    output logic [WIDTH-1:0] o_quo,
    output logic [WIDTH-1:0] o_rem
);

    logic             r_valid;
    logic [WIDTH-1:0] r_num;
    logic [WIDTH-1:0] r_den;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_rem;

    logic             n_valid;
    logic [WIDTH-1:0] n_num;
    logic [WIDTH-1:0] n_quo;
    logic [WIDTH-1:0] n_rem;

    logic [WIDTH:0]   w_trial;
    logic [WIDTH:0]   w_diff;
    logic             w_take;
    logic             w_load;

    // Stage frees up when empty or when its word moves on this cycle.
    assign o_ready = !r_valid || i_ready;
    assign w_load  = o_ready && i_valid;

    always_comb begin
        // Shift next dividend bit into the partial remainder; keep carry bit.
        w_trial = {i_rem, i_num[WIDTH-1]};
        w_diff  = w_trial - {1'b0, i_den};
        // No borrow means the trial remainder covers the divisor.
        w_take  = !w_diff[WIDTH];
        n_rem   = w_take ? w_diff[WIDTH-1:0] : w_trial[WIDTH-1:0];
        n_quo   = {i_quo[WIDTH-2:0], w_take};
        n_num   = {i_num[WIDTH-2:0], 1'b0};
        n_valid = o_ready ? i_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_num <= n_num;
            r_den <= i_den;
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_rem   = r_rem;

endmodule

// ===== rtl/unsigned_64bit_divider_unit.sv =====
`timescale 1ns / 1ps
// Pipelined unsigned restoring divider: quotient, remainder, zero-divisor flag.
// One register stage per quotient bit, each stage one subtract and select.
// Throughput: one word per cycle while the output is not stalled; each stage holds its word on a stall and
// refills as soon as its word moves on, so bubbles collapse.
// Reset: synchronous active-low i_rst_n clears all stage valid bits.
module unsigned_64bit_divider_unit import udiv_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    udiv_req_if.sink    i_req,
    udiv_rsp_if.source  o_rsp
);

    logic                  s_valid [DATA_WIDTH+1];
    logic                  s_ready [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] s_num   [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] s_den   [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] s_quo   [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] s_rem   [DATA_WIDTH+1];

    t_div_rsp w_rsp;

    // Feed the low DATA_WIDTH bits of each field into the first step.
    assign s_valid[0]  = i_req.valid;
    assign i_req.ready = s_ready[0];
    assign s_num[0]    = i_req.data.dividend[DATA_WIDTH-1:0];
    assign s_den[0]    = i_req.data.divisor[DATA_WIDTH-1:0];
    assign s_quo[0]    = '0;
    assign s_rem[0]    = '0;

    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_step
        udiv_stage #(
            .WIDTH (DATA_WIDTH)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .o_ready (s_ready[g]),
            .i_num   (s_num[g]),
            .i_den   (s_den[g]),
            .i_quo   (s_quo[g]),
            .i_rem   (s_rem[g]),
            .o_valid (s_valid[g+1]),
            .i_ready (s_ready[g+1]),
            .o_num   (s_num[g+1]),
            .o_den   (s_den[g+1]),
            .o_quo   (s_quo[g+1]),
            .o_rem   (s_rem[g+1])
        );
    end

    // Zero-extend results; the flag comes from the divisor carried alongside.
    always_comb begin
        w_rsp                                = '0;
        w_rsp.quotient[DATA_WIDTH-1:0]       = s_quo[DATA_WIDTH];
        w_rsp.remainder[DATA_WIDTH-1:0]      = s_rem[DATA_WIDTH];
        w_rsp.divide_by_zero                 = (s_den[DATA_WIDTH] == '0);
    end

    assign s_ready[DATA_WIDTH] = o_rsp.ready;
    assign o_rsp.valid         = s_valid[DATA_WIDTH];
    assign o_rsp.data          = w_rsp;

endmodule
